// File: hw/rtl/bsr_pkg.sv
// Types and constants shared by the brush stroke rasteriser.
// No dependencies; used by brush_stroke_rasterizer.
package bsr_pkg;

    localparam int COORD_W = 13;
    localparam int DELTA_W = 14;
    localparam int ERR_W   = 16;
    localparam int PIX_W   = 11;
    localparam int COLOR_W = 32;
    localparam int RAD_W   = 5;
    localparam int DIM_W   = 12;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COORD_W:0]   coord_wide_t;
    typedef logic [DELTA_W-1:0]        delta_t;
    typedef logic signed [ERR_W-1:0]   err_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_DISC = 2'd1,
        MODE_LINE = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        OP_PRESS   = 3'd0,
        OP_RELEASE = 3'd1,
        OP_MOVE    = 3'd2,
        OP_LEAVE   = 3'd3,
        OP_STEP    = 3'd4
    } op_t;

    localparam logic [CFG_IDX_W-1:0] REG_BRUSH_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

    localparam logic [RAD_W-1:0]   RADIUS_RESET = 5'd4;
    localparam logic [DIM_W-1:0]   DIM_RESET    = 12'd1024;

endpackage

// File: hw/rtl/brush_stroke_rasterizer.sv
// Brush stroke rasteriser: pointer events in, one pixel-write word out per event.
// Depends on bsr_pkg (types, op and mode codes, register indexes).
//
// Usage:
//   Input channel (in_valid/in_stall) carries one event word: operation,
//   left_button, point_x, point_y. A left press stamps a disc; a release or a
//   move while pressed walks a Bresenham line to the new point, stamping a disc
//   at each point but the end with the higher major-axis coordinate. Each step
//   tick scans one pixel of the current disc's clipped box and may write it.
//   Output channel (out_valid/out_stall) returns exactly one word per event:
//   write_valid, pixel_x, pixel_y, pixel_color, busy_res, event_dropped.
//   Config channel (cfg_valid/cfg_ready, always ready) writes brush_radius,
//   draw_color, image_width and image_height by index; write only when idle.
// Timing:
//   Result is registered and appears in the cycle after the event is accepted. One event
//   per cycle is accepted unless stalled, set by the single state update and output register.
//   When the receiver stalls, the held result stays and in_stall rises in the
//   same cycle; acceptance resumes in the cycle the result is taken.
// Reset: stroke state idle, not pressed, last point (-1,-1), registers to
//   radius 4, colour 0, canvas 1024 x 1024; no result pending.
module brush_stroke_rasterizer #(
    parameter int IMAGE_DIM_MAX = 2048,
    parameter int RADIUS_MAX    = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [2:0]                       operation,
    input  logic                             left_button,
    input  logic signed [bsr_pkg::COORD_W-1:0] point_x,
    input  logic signed [bsr_pkg::COORD_W-1:0] point_y,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             write_valid,
    output logic [bsr_pkg::PIX_W-1:0]        pixel_x,
    output logic [bsr_pkg::PIX_W-1:0]        pixel_y,
    output logic [bsr_pkg::COLOR_W-1:0]      pixel_color,
    output logic                             busy_res,
    output logic                             event_dropped,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bsr_pkg::COLOR_W-1:0]      cfg_data
);

    localparam int R_CAP   = (RADIUS_MAX > 31) ? 31 : RADIUS_MAX;
    localparam int DIM_CAP = (IMAGE_DIM_MAX > 4095) ? 4095 : IMAGE_DIM_MAX;

    // configuration registers
    logic [bsr_pkg::RAD_W-1:0]   brush_radius_reg;
    logic [bsr_pkg::COLOR_W-1:0] draw_color_reg;
    logic [bsr_pkg::DIM_W-1:0]   image_width_reg;
    logic [bsr_pkg::DIM_W-1:0]   image_height_reg;

    // stroke state
    logic            pressed_reg, pressed_next;
    bsr_pkg::coord_t current_x_reg, current_x_next;
    bsr_pkg::coord_t current_y_reg, current_y_next;
    bsr_pkg::coord_t line_major_reg, line_major_next;
    bsr_pkg::coord_t line_minor_reg, line_minor_next;
    bsr_pkg::coord_t line_end_major_reg, line_end_major_next;
    bsr_pkg::delta_t line_delta_major_reg, line_delta_major_next;
    bsr_pkg::delta_t line_delta_minor_reg, line_delta_minor_next;
    bsr_pkg::err_t   line_error_reg, line_error_next;
    logic            line_minor_down_reg, line_minor_down_next;
    logic            line_steep_reg, line_steep_next;
    bsr_pkg::coord_t disc_center_x_reg, disc_center_x_next;
    bsr_pkg::coord_t disc_center_y_reg, disc_center_y_next;
    bsr_pkg::coord_t scan_x_reg, scan_x_next;
    bsr_pkg::coord_t scan_y_reg, scan_y_next;
    bsr_pkg::mode_t  mode_reg, mode_next;

    // result register
    logic                        out_valid_reg;
    logic                        write_valid_reg;
    logic [bsr_pkg::PIX_W-1:0]   pixel_x_reg;
    logic [bsr_pkg::PIX_W-1:0]   pixel_y_reg;
    logic [bsr_pkg::COLOR_W-1:0] pixel_color_reg;
    logic                        busy_res_reg;
    logic                        event_dropped_reg;

    logic accept;
    logic is_event;
    logic step_write;
    logic dropped;

    // live clipped parameters
    logic [bsr_pkg::RAD_W-1:0] r_eff;
    logic [bsr_pkg::DIM_W-1:0] w_eff;
    logic [bsr_pkg::DIM_W-1:0] h_eff;

    // box of the current disc
    bsr_pkg::coord_wide_t box_xlo, box_xhi, box_ylo, box_yhi;
    bsr_pkg::coord_wide_t sx_wide, sy_wide, sx_inc, sx_adv, sy_adv;
    logic                 box_empty;
    logic                 row_wrap;
    logic                 disc_end;
    logic [bsr_pkg::DELTA_W-1:0]   dist_x, dist_y;
    logic [2*bsr_pkg::DELTA_W:0]   dist_sq;
    logic [2*bsr_pkg::RAD_W-1:0]   r_sq;

    // line setup from the previous point to the new one
    bsr_pkg::coord_wide_t  ls_dx, ls_dy;
    bsr_pkg::delta_t       ls_adx, ls_ady;
    logic                  ls_steep;
    bsr_pkg::coord_t       ls_a1, ls_b1, ls_a2, ls_b2;
    logic                  ls_swap;
    bsr_pkg::coord_t       ls_maj_lo, ls_min_lo, ls_maj_hi, ls_min_hi;
    bsr_pkg::coord_wide_t  ls_dmin_s;
    bsr_pkg::delta_t       ls_dmaj, ls_dmin;
    logic                  ls_run;
    bsr_pkg::coord_t       ls_cx, ls_cy;

    // advance along an active line after a disc completes
    logic signed [bsr_pkg::ERR_W:0] ln_err_sub, ln_err_fix;
    logic                           ln_err_neg;
    bsr_pkg::coord_t                ln_minor, ln_major;
    logic                           ln_run;
    bsr_pkg::coord_t                ln_cx, ln_cy;

    function automatic bsr_pkg::coord_t box_low(input bsr_pkg::coord_t c,
                                                input logic [bsr_pkg::RAD_W-1:0] r);
        bsr_pkg::coord_wide_t v;
        v = bsr_pkg::coord_wide_t'(c) - $signed({9'b0, r});
        return (v < 0) ? '0 : v[bsr_pkg::COORD_W-1:0];
    endfunction

    function automatic bsr_pkg::coord_wide_t box_high(input bsr_pkg::coord_t c,
                                                      input logic [bsr_pkg::RAD_W-1:0] r,
                                                      input logic [bsr_pkg::DIM_W-1:0] lim);
        bsr_pkg::coord_wide_t v;
        bsr_pkg::coord_wide_t l;
        v = bsr_pkg::coord_wide_t'(c) + $signed({9'b0, r});
        l = $signed({2'b00, lim});
        return (v > l) ? l : v;
    endfunction

    function automatic bsr_pkg::delta_t abs_wide(input bsr_pkg::coord_wide_t v);
        return (v < 0) ? bsr_pkg::delta_t'(-v) : bsr_pkg::delta_t'(v);
    endfunction

    assign accept    = in_valid && !in_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign cfg_ready = 1'b1;
    assign is_event  = operation inside {bsr_pkg::OP_PRESS, bsr_pkg::OP_RELEASE,
                                         bsr_pkg::OP_MOVE, bsr_pkg::OP_LEAVE};

    assign r_eff = (brush_radius_reg > bsr_pkg::RAD_W'(R_CAP)) ?
                   bsr_pkg::RAD_W'(R_CAP) : brush_radius_reg;
    assign w_eff = (image_width_reg > bsr_pkg::DIM_W'(DIM_CAP)) ?
                   bsr_pkg::DIM_W'(DIM_CAP) : image_width_reg;
    assign h_eff = (image_height_reg > bsr_pkg::DIM_W'(DIM_CAP)) ?
                   bsr_pkg::DIM_W'(DIM_CAP) : image_height_reg;

    // scan of the current disc box
    always_comb
    begin
        box_xlo   = bsr_pkg::coord_wide_t'(box_low(disc_center_x_reg, r_eff));
        box_ylo   = bsr_pkg::coord_wide_t'(box_low(disc_center_y_reg, r_eff));
        box_xhi   = box_high(disc_center_x_reg, r_eff, w_eff);
        box_yhi   = box_high(disc_center_y_reg, r_eff, h_eff);
        sx_wide   = bsr_pkg::coord_wide_t'(scan_x_reg);
        sy_wide   = bsr_pkg::coord_wide_t'(scan_y_reg);
        box_empty = (box_xlo >= box_xhi) || (sy_wide >= box_yhi);
        dist_x    = abs_wide(bsr_pkg::coord_wide_t'(disc_center_x_reg) - sx_wide);
        dist_y    = abs_wide(bsr_pkg::coord_wide_t'(disc_center_y_reg) - sy_wide);
        dist_sq   = (2*bsr_pkg::DELTA_W+1)'(dist_x * dist_x)
                  + (2*bsr_pkg::DELTA_W+1)'(dist_y * dist_y);
        r_sq      = (2*bsr_pkg::RAD_W)'(r_eff * r_eff);
        step_write = !box_empty && (sx_wide < box_xhi)
                   && (dist_sq <= (2*bsr_pkg::DELTA_W+1)'(r_sq));
        sx_inc    = sx_wide + 14'sd1;
        row_wrap  = (sx_inc >= box_xhi);
        sx_adv    = row_wrap ? box_xlo : sx_inc;
        sy_adv    = row_wrap ? (sy_wide + 14'sd1) : sy_wide;
        disc_end  = box_empty || (sy_adv >= box_yhi);
    end

    // line setup: order the end points along the major axis
    always_comb
    begin
        ls_dx     = bsr_pkg::coord_wide_t'(point_x) - bsr_pkg::coord_wide_t'(current_x_reg);
        ls_dy     = bsr_pkg::coord_wide_t'(point_y) - bsr_pkg::coord_wide_t'(current_y_reg);
        ls_adx    = abs_wide(ls_dx);
        ls_ady    = abs_wide(ls_dy);
        ls_steep  = ls_ady > ls_adx;
        ls_a1     = ls_steep ? current_y_reg : current_x_reg;
        ls_b1     = ls_steep ? current_x_reg : current_y_reg;
        ls_a2     = ls_steep ? point_y : point_x;
        ls_b2     = ls_steep ? point_x : point_y;
        ls_swap   = ls_a1 > ls_a2;
        ls_maj_lo = ls_swap ? ls_a2 : ls_a1;
        ls_min_lo = ls_swap ? ls_b2 : ls_b1;
        ls_maj_hi = ls_swap ? ls_a1 : ls_a2;
        ls_min_hi = ls_swap ? ls_b1 : ls_b2;
        ls_dmaj   = bsr_pkg::delta_t'(bsr_pkg::coord_wide_t'(ls_maj_hi)
                                    - bsr_pkg::coord_wide_t'(ls_maj_lo));
        ls_dmin_s = bsr_pkg::coord_wide_t'(ls_min_hi) - bsr_pkg::coord_wide_t'(ls_min_lo);
        ls_dmin   = abs_wide(ls_dmin_s);
        ls_run    = ls_maj_lo < ls_maj_hi;
        ls_cx     = ls_steep ? ls_min_lo : ls_maj_lo;
        ls_cy     = ls_steep ? ls_maj_lo : ls_min_lo;
    end

    // next line point: doubled integer error keeps the walk exact
    always_comb
    begin
        ln_err_sub = (bsr_pkg::ERR_W+1)'(line_error_reg)
                   - $signed({2'b00, line_delta_minor_reg, 1'b0});
        ln_err_neg = ln_err_sub < 0;
        ln_err_fix = ln_err_neg ?
                     (ln_err_sub + $signed({2'b00, line_delta_major_reg, 1'b0})) :
                     ln_err_sub;
        if (!ln_err_neg)
        begin
            ln_minor = line_minor_reg;
        end
        else if (line_minor_down_reg)
        begin
            ln_minor = line_minor_reg - 13'sd1;
        end
        else
        begin
            ln_minor = line_minor_reg + 13'sd1;
        end
        ln_major = line_major_reg + 13'sd1;
        ln_run   = ln_major < line_end_major_reg;
        ln_cx    = line_steep_reg ? ln_minor : ln_major;
        ln_cy    = line_steep_reg ? ln_major : ln_minor;
    end

    // next state
    always_comb
    begin
        pressed_next          = pressed_reg;
        current_x_next        = current_x_reg;
        current_y_next        = current_y_reg;
        line_major_next       = line_major_reg;
        line_minor_next       = line_minor_reg;
        line_end_major_next   = line_end_major_reg;
        line_delta_major_next = line_delta_major_reg;
        line_delta_minor_next = line_delta_minor_reg;
        line_error_next       = line_error_reg;
        line_minor_down_next  = line_minor_down_reg;
        line_steep_next       = line_steep_reg;
        disc_center_x_next    = disc_center_x_reg;
        disc_center_y_next    = disc_center_y_reg;
        scan_x_next           = scan_x_reg;
        scan_y_next           = scan_y_reg;
        mode_next             = mode_reg;

        if (accept && !(is_event && mode_reg != bsr_pkg::MODE_IDLE))
        begin
            case (bsr_pkg::op_t'(operation))
                bsr_pkg::OP_PRESS:
                begin
                    if (left_button)
                    begin
                        pressed_next       = 1'b1;
                        current_x_next     = point_x;
                        current_y_next     = point_y;
                        mode_next          = bsr_pkg::MODE_DISC;
                        disc_center_x_next = point_x;
                        disc_center_y_next = point_y;
                        scan_x_next        = box_low(point_x, r_eff);
                        scan_y_next        = box_low(point_y, r_eff);
                    end
                end
                bsr_pkg::OP_RELEASE, bsr_pkg::OP_MOVE:
                begin
                    if (pressed_reg)
                    begin
                        if (operation == bsr_pkg::OP_RELEASE)
                        begin
                            pressed_next = 1'b0;
                        end
                        current_x_next        = point_x;
                        current_y_next        = point_y;
                        line_steep_next       = ls_steep;
                        line_delta_major_next = ls_dmaj;
                        line_delta_minor_next = ls_dmin;
                        line_minor_down_next  = !(ls_min_lo < ls_min_hi);
                        line_error_next       = bsr_pkg::err_t'({2'b00, ls_dmaj});
                        line_major_next       = ls_maj_lo;
                        line_minor_next       = ls_min_lo;
                        line_end_major_next   = ls_maj_hi;
                        if (ls_run)
                        begin
                            mode_next          = bsr_pkg::MODE_LINE;
                            disc_center_x_next = ls_cx;
                            disc_center_y_next = ls_cy;
                            scan_x_next        = box_low(ls_cx, r_eff);
                            scan_y_next        = box_low(ls_cy, r_eff);
                        end
                        else
                        begin
                            mode_next = bsr_pkg::MODE_IDLE;
                        end
                    end
                end
                bsr_pkg::OP_LEAVE:
                begin
                    pressed_next = 1'b0;
                end
                bsr_pkg::OP_STEP:
                begin
                    if (mode_reg != bsr_pkg::MODE_IDLE)
                    begin
                        if (!box_empty)
                        begin
                            scan_x_next = sx_adv[bsr_pkg::COORD_W-1:0];
                            scan_y_next = sy_adv[bsr_pkg::COORD_W-1:0];
                        end
                        if (disc_end)
                        begin
                            if (mode_reg != bsr_pkg::MODE_LINE)
                            begin
                                mode_next = bsr_pkg::MODE_IDLE;
                            end
                            else
                            begin
                                line_error_next = ln_err_fix[bsr_pkg::ERR_W-1:0];
                                line_minor_next = ln_minor;
                                line_major_next = ln_major;
                                if (ln_run)
                                begin
                                    disc_center_x_next = ln_cx;
                                    disc_center_y_next = ln_cy;
                                    scan_x_next        = box_low(ln_cx, r_eff);
                                    scan_y_next        = box_low(ln_cy, r_eff);
                                end
                                else
                                begin
                                    mode_next = bsr_pkg::MODE_IDLE;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // result fields
    always_comb
    begin
        dropped = is_event && (mode_reg != bsr_pkg::MODE_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brush_radius_reg <= bsr_pkg::RADIUS_RESET;
            draw_color_reg   <= '0;
            image_width_reg  <= bsr_pkg::DIM_RESET;
            image_height_reg <= bsr_pkg::DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bsr_pkg::REG_BRUSH_RADIUS: brush_radius_reg <= cfg_data[bsr_pkg::RAD_W-1:0];
                bsr_pkg::REG_DRAW_COLOR:   draw_color_reg   <= cfg_data;
                bsr_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[bsr_pkg::DIM_W-1:0];
                bsr_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[bsr_pkg::DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg          <= 1'b0;
            current_x_reg        <= '1;
            current_y_reg        <= '1;
            line_major_reg       <= '0;
            line_minor_reg       <= '0;
            line_end_major_reg   <= '0;
            line_delta_major_reg <= '0;
            line_delta_minor_reg <= '0;
            line_error_reg       <= '0;
            line_minor_down_reg  <= 1'b0;
            line_steep_reg       <= 1'b0;
            disc_center_x_reg    <= '0;
            disc_center_y_reg    <= '0;
            scan_x_reg           <= '0;
            scan_y_reg           <= '0;
            mode_reg             <= bsr_pkg::MODE_IDLE;
        end
        else
        begin
            pressed_reg          <= pressed_next;
            current_x_reg        <= current_x_next;
            current_y_reg        <= current_y_next;
            line_major_reg       <= line_major_next;
            line_minor_reg       <= line_minor_next;
            line_end_major_reg   <= line_end_major_next;
            line_delta_major_reg <= line_delta_major_next;
            line_delta_minor_reg <= line_delta_minor_next;
            line_error_reg       <= line_error_next;
            line_minor_down_reg  <= line_minor_down_next;
            line_steep_reg       <= line_steep_next;
            disc_center_x_reg    <= disc_center_x_next;
            disc_center_y_reg    <= disc_center_y_next;
            scan_x_reg           <= scan_x_next;
            scan_y_reg           <= scan_y_next;
            mode_reg             <= mode_next;
        end
    end

    // hold the result until taken; load a new one on every accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            write_valid_reg   <= (operation == bsr_pkg::OP_STEP)
                                 && (mode_reg != bsr_pkg::MODE_IDLE) && step_write;
            pixel_x_reg       <= '0;
            pixel_y_reg       <= '0;
            pixel_color_reg   <= '0;
            if ((operation == bsr_pkg::OP_STEP) && (mode_reg != bsr_pkg::MODE_IDLE)
                && step_write)
            begin
                pixel_x_reg     <= scan_x_reg[bsr_pkg::PIX_W-1:0];
                pixel_y_reg     <= scan_y_reg[bsr_pkg::PIX_W-1:0];
                pixel_color_reg <= draw_color_reg;
            end
            busy_res_reg      <= (mode_next != bsr_pkg::MODE_IDLE);
            event_dropped_reg <= dropped;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_valid   = write_valid_reg;
    assign pixel_x       = pixel_x_reg;
    assign pixel_y       = pixel_y_reg;
    assign pixel_color   = pixel_color_reg;
    assign busy_res      = busy_res_reg;
    assign event_dropped = event_dropped_reg;

    // a dropped event never writes a pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(event_dropped_reg && write_valid_reg))
        else $error("dropped event produced a pixel write");

    // a step tick while idle writes nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == bsr_pkg::OP_STEP && mode_reg == bsr_pkg::MODE_IDLE)
        |=> !write_valid_reg)
        else $error("pixel written while idle");

    // busy flag follows the stroke mode left by the word
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_res_reg == (mode_reg != bsr_pkg::MODE_IDLE)))
        else $error("busy flag disagrees with stroke mode");

    // nothing is dropped while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_reg == bsr_pkg::MODE_IDLE) |=> !event_dropped_reg)
        else $error("event dropped while idle");

endmodule
